/* rtl/clist_pkg.sv */
`default_nettype none

package clist_pkg;

   localparam int POOL_DEPTH = 64;
   localparam int IDX_W      = $clog2(POOL_DEPTH);
   localparam int CNT_W      = $clog2(POOL_DEPTH + 1);
   localparam int VALUE_W    = 32;
   localparam int FUNC_W     = 2;
   localparam int STATUS_W   = 3;

   localparam logic [FUNC_W-1:0] FUNC_INSERT  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_DELETE  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_DISPLAY = 2'd2;

   typedef logic [STATUS_W-1:0] status_code_type;

   localparam status_code_type ST_INSERTED  = 3'd0;
   localparam status_code_type ST_DELETED   = 3'd1;
   localparam status_code_type ST_NOT_FOUND = 3'd2;
   localparam status_code_type ST_EMPTY     = 3'd3;
   localparam status_code_type ST_LIST_ITEM = 3'd4;
   localparam status_code_type ST_FULL      = 3'd5;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_INS_NODE,
      S_INS_LINK,
      S_DEL_SEARCH,
      S_DEL_UNLINK,
      S_DISP_WALK,
      S_REPLY
   } state_type;

   typedef struct packed {
      logic            capture;
      logic            ins_read;
      logic            ins_node;
      logic            ins_link;
      logic            walk_start;
      logic            walk_step;
      logic            unlink;
      logic            emit;
      status_code_type emit_status;
      logic            emit_last;
   } clist_cmd_type;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic              empty;
      logic              full;
      logic              match;
      logic              walk_last;
      logic              out_free;
   } clist_sts_type;

endpackage

`default_nettype wire

/* rtl/circular_ordered_list_engine_top.sv */
// From request to first result: insert decodes, writes the node, links it behind the tail
// (not for an empty list) and replies; a full pool replies after decode. Delete walks to
// the match or the tail, unlinks a match and replies; display sends one item per cycle
// while the output is free. One request at a time; the next is taken once the last result
// is loaded. Throughput is set by the list walk, one node memory read per cycle when not held.
// Reset empties the list and restores the free stack through valid bits at once; the node
// memories are not cleared and no clearing pass runs.
`default_nettype none

module circular_ordered_list_engine_top
   import clist_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic [FUNC_W-1:0]         req_func,
   input  wire logic signed [VALUE_W-1:0] req_item_value,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic [STATUS_W-1:0]            rsp_status,
   output logic signed [VALUE_W-1:0]      rsp_out_value,
   output logic                           rsp_last
);

   clist_cmd_type cmd;
   clist_sts_type sts;

   clist_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   clist_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .req_func       (req_func),
      .req_item_value (req_item_value),
      .cmd            (cmd),
      .sts            (sts),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_out_value  (rsp_out_value),
      .rsp_last       (rsp_last)
   );

   // A result is never loaded over one that is still waiting.
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid || rsp_ready))
      else $error("result loaded while output register busy");

   // No node is allocated from a full pool.
   a_ins_not_full: assert property (@(posedge clock) disable iff (reset)
      cmd.ins_node |-> !sts.full)
      else $error("insert into full pool");

   // The walk never steps past the last node, and no request is taken meanwhile.
   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.walk_step |-> (!sts.walk_last && !req_ready))
      else $error("walk stepped past the tail");

   // Unlinking only follows a match on a non-empty list.
   a_unlink_match: assert property (@(posedge clock) disable iff (reset)
      cmd.unlink |-> ($past(sts.match) && !sts.empty))
      else $error("unlink without a match");

endmodule

`default_nettype wire

/* rtl/clist_ctrl.sv */
`default_nettype none

module clist_ctrl
   import clist_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   input  wire clist_sts_type sts,
   output clist_cmd_type      cmd
);

   state_type       state_ff, state_in;
   status_code_type reply_ff, reply_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         reply_ff <= ST_INSERTED;
      end else begin
         state_ff <= state_in;
         reply_ff <= reply_in;
      end
   end

   // Next state, and the status of a single-result reply.
   always_comb begin
      state_in = state_ff;
      reply_in = reply_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            unique case (sts.func)
               FUNC_INSERT: begin
                  if (sts.full) begin
                     state_in = S_REPLY;
                     reply_in = ST_FULL;
                  end else begin
                     state_in = S_INS_NODE;
                  end
               end
               FUNC_DELETE: begin
                  if (sts.empty) begin
                     state_in = S_REPLY;
                     reply_in = ST_EMPTY;
                  end else begin
                     state_in = S_DEL_SEARCH;
                  end
               end
               FUNC_DISPLAY: begin
                  if (sts.empty) begin
                     state_in = S_REPLY;
                     reply_in = ST_EMPTY;
                  end else begin
                     state_in = S_DISP_WALK;
                  end
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end
         S_INS_NODE: begin
            reply_in = ST_INSERTED;
            state_in = sts.empty ? S_REPLY : S_INS_LINK;
         end
         S_INS_LINK: begin
            reply_in = ST_INSERTED;
            state_in = S_REPLY;
         end
         S_DEL_SEARCH: begin
            priority if (sts.match) begin
               state_in = S_DEL_UNLINK;
            end else if (sts.walk_last) begin
               state_in = S_REPLY;
               reply_in = ST_NOT_FOUND;
            end else begin
               state_in = S_DEL_SEARCH;
            end
         end
         S_DEL_UNLINK: begin
            state_in = S_REPLY;
            reply_in = ST_DELETED;
         end
         S_DISP_WALK: begin
            if (sts.out_free && sts.walk_last) begin
               state_in = S_IDLE;
            end
         end
         S_REPLY: begin
            if (sts.out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         S_DECODE: begin
            cmd.ins_read   = (sts.func == FUNC_INSERT) && !sts.full;
            cmd.walk_start = ((sts.func == FUNC_DELETE) || (sts.func == FUNC_DISPLAY))
                             && !sts.empty;
         end
         S_INS_NODE: begin
            cmd.ins_node = 1'b1;
         end
         S_INS_LINK: begin
            cmd.ins_link = 1'b1;
         end
         S_DEL_SEARCH: begin
            cmd.walk_step = !sts.match && !sts.walk_last;
         end
         S_DEL_UNLINK: begin
            cmd.unlink = 1'b1;
         end
         S_DISP_WALK: begin
            if (sts.out_free) begin
               cmd.emit        = 1'b1;
               cmd.emit_status = ST_LIST_ITEM;
               cmd.emit_last   = sts.walk_last;
               cmd.walk_step   = !sts.walk_last;
            end
         end
         S_REPLY: begin
            if (sts.out_free) begin
               cmd.emit        = 1'b1;
               cmd.emit_status = reply_ff;
               cmd.emit_last   = 1'b1;
            end
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

`default_nettype wire

/* rtl/clist_dp.sv */
`default_nettype none

module clist_dp
   import clist_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic [FUNC_W-1:0]    req_func,
   input  wire logic signed [VALUE_W-1:0] req_item_value,
   input  wire clist_cmd_type        cmd,
   output clist_sts_type             sts,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [STATUS_W-1:0]       rsp_status,
   output logic signed [VALUE_W-1:0] rsp_out_value,
   output logic                      rsp_last
);

   // Node storage: one read and one write port each, read data registered.
   logic signed [VALUE_W-1:0] value_mem [POOL_DEPTH];
   logic [IDX_W-1:0]          next_mem  [POOL_DEPTH];
   logic [IDX_W-1:0]          prev_mem  [POOL_DEPTH];
   logic [IDX_W-1:0]          fs_mem    [POOL_DEPTH];
   logic [POOL_DEPTH-1:0]     fs_valid_ff;

   logic [FUNC_W-1:0]         func_ff;
   logic signed [VALUE_W-1:0] val_ff;
   logic [IDX_W-1:0]          head_ff, head_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic [IDX_W-1:0]          cur_ff;
   logic [IDX_W-1:0]          idx_ff;
   logic signed [VALUE_W-1:0] value_rd_ff;
   logic [IDX_W-1:0]          next_rd_ff;
   logic [IDX_W-1:0]          prev_rd_ff;
   logic [IDX_W-1:0]          fs_rd_ff;
   logic                      fs_vld_rd_ff;
   logic [IDX_W-1:0]          slot_ff;

   logic                      rsp_valid_ff;
   status_code_type           rsp_status_ff;
   logic signed [VALUE_W-1:0] rsp_value_ff;
   logic                      rsp_last_ff;

   logic [IDX_W-1:0]          walk_addr;
   logic [IDX_W-1:0]          prev_addr;
   logic [IDX_W-1:0]          new_node;
   logic [CNT_W-1:0]          count_dec;
   logic [IDX_W-1:0]          fs_top;
   logic                      multi;

   logic                      next_we;
   logic [IDX_W-1:0]          next_wa, next_wd;
   logic                      prev_we;
   logic [IDX_W-1:0]          prev_wa, prev_wd;

   assign walk_addr = cmd.walk_start ? head_ff : next_rd_ff;
   assign prev_addr = cmd.ins_read ? head_ff : walk_addr;
   // A free-stack entry that was never pushed is invalid; its own slot index is used instead.
   assign new_node  = fs_vld_rd_ff ? fs_rd_ff : slot_ff;
   assign count_dec = count_ff - CNT_W'(1);
   assign fs_top    = count_dec[IDX_W-1:0];
   assign multi     = count_ff > CNT_W'(1);

   assign sts.func      = func_ff;
   assign sts.empty     = (count_ff == '0);
   assign sts.full      = (count_ff == CNT_W'(POOL_DEPTH));
   assign sts.match     = (value_rd_ff == val_ff);
   assign sts.walk_last = (CNT_W'(idx_ff) == count_dec);
   assign sts.out_free  = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff <= req_func;
         val_ff  <= req_item_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      if (cmd.ins_node) begin
         count_in = count_ff + CNT_W'(1);
         if (count_ff == '0) begin
            head_in = new_node;
         end
      end
      if (cmd.unlink) begin
         count_in = count_dec;
         if (multi && (cur_ff == head_ff)) begin
            head_in = next_rd_ff;
         end
      end
   end

   // Walk position: the node whose data sits in the read registers.
   always_ff @(posedge clock) begin
      if (cmd.walk_start || cmd.walk_step) begin
         cur_ff <= walk_addr;
         idx_ff <= cmd.walk_start ? '0 : idx_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.walk_start || cmd.walk_step) begin
         value_rd_ff <= value_mem[walk_addr];
         next_rd_ff  <= next_mem[walk_addr];
      end
      if (cmd.walk_start || cmd.walk_step || cmd.ins_read) begin
         prev_rd_ff <= prev_mem[prev_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.ins_node) begin
         value_mem[new_node] <= val_ff;
      end
   end

   // Link writes. While inserting, prev_rd_ff holds the tail.
   always_comb begin
      next_we = 1'b0;
      next_wa = new_node;
      next_wd = new_node;
      prev_we = 1'b0;
      prev_wa = new_node;
      prev_wd = new_node;
      priority if (cmd.ins_node) begin
         next_we = 1'b1;
         next_wd = (count_ff == '0) ? new_node : head_ff;
         prev_we = 1'b1;
         prev_wd = (count_ff == '0) ? new_node : prev_rd_ff;
      end else if (cmd.ins_link) begin
         next_we = 1'b1;
         next_wa = prev_rd_ff;
         next_wd = new_node;
         prev_we = 1'b1;
         prev_wa = head_ff;
         prev_wd = new_node;
      end else if (cmd.unlink && multi) begin
         next_we = 1'b1;
         next_wa = prev_rd_ff;
         next_wd = next_rd_ff;
         prev_we = 1'b1;
         prev_wa = next_rd_ff;
         prev_wd = prev_rd_ff;
      end else begin
         next_we = 1'b0;
         prev_we = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (next_we) begin
         next_mem[next_wa] <= next_wd;
      end
      if (prev_we) begin
         prev_mem[prev_wa] <= prev_wd;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.unlink) begin
         fs_mem[fs_top] <= cur_ff;
      end
      if (cmd.ins_read) begin
         fs_rd_ff     <= fs_mem[count_ff[IDX_W-1:0]];
         fs_vld_rd_ff <= fs_valid_ff[count_ff[IDX_W-1:0]];
         slot_ff      <= count_ff[IDX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fs_valid_ff <= '0;
      end else if (cmd.unlink) begin
         fs_valid_ff[fs_top] <= 1'b1;
      end
   end

   // Output register: the next item may be loaded in the cycle the held one is taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_status_ff <= cmd.emit_status;
         rsp_last_ff   <= cmd.emit_last;
         priority if (cmd.emit_status == ST_LIST_ITEM) begin
            rsp_value_ff <= value_rd_ff;
         end else if (cmd.emit_status == ST_DELETED) begin
            rsp_value_ff <= val_ff;
         end else begin
            rsp_value_ff <= '0;
         end
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_out_value = rsp_value_ff;
   assign rsp_last      = rsp_last_ff;

endmodule

`default_nettype wire
